[rtl/sbpla_pkg.sv]
// Package for the shared bus priority lock arbiter.
// Types, opcode/kind/status codes and policy tables. No dependencies.
package sbpla_pkg;

  localparam int WAITER_SLOTS_DEF = 8;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int MAX_TICK_RESULTS = 8;
  localparam logic [31:0] BUDGET_RESET = 32'd100;
  localparam logic [31:0] DEGRADE_STREAK = 32'd3;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [2:0] K_GRANTED  = 3'd0;
  localparam logic [2:0] K_NESTED   = 3'd1;
  localparam logic [2:0] K_QUEUED   = 3'd2;
  localparam logic [2:0] K_BUSY     = 3'd3;
  localparam logic [2:0] K_TIMEDOUT = 3'd4;
  localparam logic [2:0] K_PARTIAL  = 3'd5;
  localparam logic [2:0] K_FULL     = 3'd6;
  localparam logic [2:0] K_MISMATCH = 3'd7;

  localparam logic [1:0] H_HEALTHY  = 2'd0;
  localparam logic [1:0] H_SLOW     = 2'd1;
  localparam logic [1:0] H_DEGRADED = 2'd2;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_TIMEOUT  = 2'd1;
  localparam logic [1:0] E_HOLD     = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [2:0]  policy;
    logic [31:0] due_ms;
    logic [31:0] now_ms;
    logic        token_valid;
    logic [31:0] token_gen;
    logic [7:0]  token_depth;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  for_task;
    logic [31:0] generation;
    logic [7:0]  depth;
    logic [31:0] wait_ms;
    logic [1:0]  health_status;
    logic [1:0]  health_error;
    logic [31:0] max_hold_ms;
    logic [31:0] mismatch_count;
    logic        last;
  } res_t;

  function automatic logic [2:0] class_of(input logic [2:0] pol);
    case (pol)
      3'd0, 3'd1: class_of = 3'd0;
      3'd2:       class_of = 3'd1;
      3'd3:       class_of = 3'd2;
      3'd4:       class_of = 3'd3;
      default:    class_of = 3'd4;
    endcase
  endfunction

  function automatic logic [31:0] timeout_of(input logic [2:0] pol);
    case (pol)
      3'd0:    timeout_of = 32'd0;
      3'd1:    timeout_of = 32'd45;
      3'd2:    timeout_of = 32'd200;
      3'd3:    timeout_of = 32'd250;
      3'd4:    timeout_of = 32'd500;
      default: timeout_of = 32'd25;
    endcase
  endfunction

endpackage

[rtl/sbpla_if.sv]
// Valid/ready channel interfaces for the lock arbiter request and result beats.
// Depends on sbpla_pkg.
interface sbpla_in_if import sbpla_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbpla_out_if import sbpla_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/shared_bus_priority_lock_arbiter.sv]
// Shared bus priority lock arbiter: reentrant lock, waiter table, health status.
// Depends on sbpla_pkg and the sbpla_in_if / sbpla_out_if interfaces.
//
// Usage:
//   req  : request beats (acquire, release, tick); taken only while the block is idle.
//   rsp  : result beats, none to eight per request; the final one has last set.
//   cfg  : cfg_we/cfg_wdata write the slow-hold budget (reset value 100).
// The waiter table sits in a synchronous memory; valid bits are flops.
// Steps: nested acquire, table-full refusal, mismatch and partial release pass decode
//   and flush; acquire while the lock is held passes decode, acquire end and flush.
//   Full release and tick scan the table one entry per cycle unless stalled; acquire
//   of a free lock scans, then reaches acquire end; a grant adds grant read and grant.
//   The next request is accepted in the cycle after the last beat is loaded.
// Results pass a one-beat pending stage and an output register; a request is
//   accepted while the last result still waits in the output register.
// If the receiver stalls, the block holds its scan until a result can move on.
// Reset clears the valid bits, owner, counters and health at once; there is no
//   clearing pass.
module shared_bus_priority_lock_arbiter
  import sbpla_pkg::*;
#(
  parameter int WAITER_SLOTS = WAITER_SLOTS_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  sbpla_in_if.sink    req,
  sbpla_out_if.source rsp
);

  localparam int N  = WAITER_SLOTS;
  localparam int TB = TASK_ID_BITS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int SW = $clog2(N + 1);
  localparam int FW = $clog2(MAX_TICK_RESULTS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEC      = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_ACQ_END  = 3'd3;
  localparam logic [2:0] S_GRANT_RD = 3'd4;
  localparam logic [2:0] S_GRANT    = 3'd5;
  localparam logic [2:0] S_FLUSH    = 3'd6;

  logic [2:0] state;
  item_t      it;
  logic [31:0] budget;
  logic [31:0] tmo;
  logic        mode_tick;

  // waiter table
  logic [TB-1:0] mem_task [N];
  logic [2:0]    mem_cls [N];
  logic [31:0]   mem_ord [N];
  logic [31:0]   mem_dl [N];
  logic [31:0]   mem_start [N];
  logic [TB-1:0] rd_task;
  logic [2:0]    rd_cls;
  logic [31:0]   rd_ord, rd_dl, rd_start;
  logic [N-1:0]  wvalid;

  logic          owner_present;
  logic [TB-1:0] owner_id;
  logic [31:0]   owner_gen, owner_since, next_order, streak, longest, mm_total;
  logic [7:0]    owner_depth;
  logic [1:0]    health, err;

  logic [SW-1:0] s;
  logic          cmp_v;
  logic [IW-1:0] cmp_i, best_i, slot;
  logic          best_v;
  logic [2:0]    best_cls;
  logic [31:0]   best_ord;
  logic [FW-1:0] found;

  res_t pend, pend_last, out_data;
  logic pend_valid, out_valid;

  logic [15:0]   tid_ext;
  logic [TB-1:0] ltask;
  logic [7:0]    rd_task8, ltask8;
  logic [15:0]   rd_task_ext, ltask_ext;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   tmo_c, dd, hold, gen_next, streak_inc, order_inc;
  logic [1:0]    h_to;
  logic          own_hit, match, expired, better, scan_end, tick_hit, grant_here;
  logic          push, can_push, go, stall, rd_en;
  logic [IW-1:0] rd_addr;
  res_t          res_new;

  assign tid_ext     = {8'd0, it.task_id};
  assign ltask       = tid_ext[TB-1:0];
  assign rd_task_ext = 16'(rd_task);
  assign ltask_ext   = 16'(ltask);
  assign rd_task8    = rd_task_ext[7:0];
  assign ltask8      = ltask_ext[7:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!wvalid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    tmo_c = timeout_of(it.policy);
    dd    = it.due_ms - it.now_ms;
    if (it.due_ms != 32'd0) begin
      if (dd[31]) begin
        tmo_c = 32'd0;
      end else if (dd < tmo_c) begin
        tmo_c = dd;
      end
    end
  end

  always_comb begin
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  assign streak_inc = streak + 32'd1;
  assign h_to       = (streak_inc >= DEGRADE_STREAK) ? H_DEGRADED : H_SLOW;
  assign gen_next   = (owner_gen == 32'hFFFF_FFFF) ? 32'd1 : owner_gen + 32'd1;
  assign order_inc  = (next_order == 32'hFFFF_FFFF) ? 32'd1 : next_order + 32'd1;
  assign hold       = it.now_ms - owner_since;
  assign own_hit    = owner_present && (owner_id == ltask);
  assign match      = it.token_valid && owner_present && (owner_id == ltask) &&
                      (it.token_gen == owner_gen) && (it.token_depth == owner_depth);
  assign expired    = ((rd_dl - it.now_ms) == 32'd0) || ((rd_dl - it.now_ms) >= 32'h8000_0000);
  assign better     = !best_v || (rd_cls < best_cls) ||
                      ((rd_cls == best_cls) && (rd_ord < best_ord));
  assign scan_end   = (mode_tick && (found == FW'(MAX_TICK_RESULTS))) ||
                      ((s == SW'(N)) && !cmp_v);
  assign tick_hit   = mode_tick && cmp_v && wvalid[cmp_i] && expired && !scan_end;
  assign grant_here = best_v && (best_i == slot);
  assign can_push   = !pend_valid || !out_valid || rsp.ready;

  always_comb begin
    push    = 1'b0;
    res_new = '{kind: K_GRANTED, for_task: ltask8, generation: 32'd0, depth: owner_depth,
                wait_ms: 32'd0, health_status: health, health_error: err,
                max_hold_ms: longest, mismatch_count: mm_total, last: 1'b0};
    case (state)
      S_DEC: begin
        if (it.opcode == OP_ACQUIRE) begin
          if (own_hit) begin
            push               = 1'b1;
            res_new.kind       = K_NESTED;
            res_new.generation = owner_gen;
            res_new.depth      = (owner_depth == 8'hFF) ? 8'hFF : owner_depth + 8'd1;
          end else if (!free_found) begin
            push                  = 1'b1;
            res_new.kind          = (tmo_c == 32'd0) ? K_BUSY : K_TIMEDOUT;
            res_new.health_status = h_to;
            res_new.health_error  = E_TIMEOUT;
          end
        end else if (it.opcode == OP_RELEASE) begin
          push               = 1'b1;
          res_new.generation = owner_gen;
          if (!match) begin
            res_new.kind           = K_MISMATCH;
            res_new.mismatch_count = mm_total + 32'd1;
          end else if (owner_depth > 8'd1) begin
            res_new.kind  = K_PARTIAL;
            res_new.depth = owner_depth - 8'd1;
          end else begin
            res_new.kind          = K_FULL;
            res_new.depth         = 8'd0;
            res_new.max_hold_ms   = (hold > longest) ? hold : longest;
            res_new.health_status = (hold > budget) ? H_SLOW : H_HEALTHY;
            res_new.health_error  = (hold > budget) ? E_HOLD : E_NONE;
          end
        end
      end
      S_SCAN: begin
        if (tick_hit) begin
          push                  = 1'b1;
          res_new.kind          = K_TIMEDOUT;
          res_new.for_task      = rd_task8;
          res_new.wait_ms       = it.now_ms - rd_start;
          res_new.health_status = h_to;
          res_new.health_error  = E_TIMEOUT;
        end
      end
      S_ACQ_END: begin
        if (!grant_here) begin
          push = 1'b1;
          if (tmo == 32'd0) begin
            res_new.kind          = K_BUSY;
            res_new.health_status = h_to;
            res_new.health_error  = E_TIMEOUT;
          end else begin
            res_new.kind = K_QUEUED;
          end
        end
      end
      S_GRANT: begin
        push               = 1'b1;
        res_new.kind       = K_GRANTED;
        res_new.for_task   = rd_task8;
        res_new.generation = gen_next;
        res_new.depth      = 8'd1;
        res_new.wait_ms    = it.now_ms - rd_start;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign go      = !push || can_push;
  assign stall   = !go;
  assign rd_addr = (state == S_GRANT_RD) ? best_i : s[IW-1:0];
  assign rd_en   = (state == S_GRANT_RD) ||
                   ((state == S_SCAN) && !stall && !scan_end && (s < SW'(N)));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_task  <= mem_task[rd_addr];
      rd_cls   <= mem_cls[rd_addr];
      rd_ord   <= mem_ord[rd_addr];
      rd_dl    <= mem_dl[rd_addr];
      rd_start <= mem_start[rd_addr];
    end
    if ((state == S_DEC) && (it.opcode == OP_ACQUIRE) && !own_hit && free_found) begin
      mem_task[free_idx]  <= ltask;
      mem_cls[free_idx]   <= class_of(it.policy);
      mem_ord[free_idx]   <= next_order;
      mem_dl[free_idx]    <= it.now_ms + tmo_c;
      mem_start[free_idx] <= it.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      budget        <= BUDGET_RESET;
      wvalid        <= '0;
      owner_present <= 1'b0;
      owner_id      <= '0;
      owner_gen     <= '0;
      owner_depth   <= '0;
      owner_since   <= '0;
      next_order    <= '0;
      streak        <= '0;
      health        <= H_HEALTHY;
      err           <= E_NONE;
      longest       <= '0;
      mm_total      <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
      cmp_v         <= 1'b0;
      best_v        <= 1'b0;
      s             <= '0;
      found         <= '0;
      mode_tick     <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (push && go) begin
        if (pend_valid) begin
          out_data  <= pend;
          out_valid <= 1'b1;
        end
        pend        <= res_new;
        pend_valid  <= 1'b1;
        health      <= res_new.health_status;
        err         <= res_new.health_error;
        longest     <= res_new.max_hold_ms;
        mm_total    <= res_new.mismatch_count;
        owner_depth <= res_new.depth;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            it    <= req.data;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          s      <= '0;
          cmp_v  <= 1'b0;
          best_v <= 1'b0;
          found  <= '0;
          state  <= S_FLUSH;
          case (it.opcode)
            OP_ACQUIRE: begin
              mode_tick <= 1'b0;
              if (!own_hit) begin
                if (!free_found) begin
                  streak <= streak_inc;
                end else begin
                  wvalid[free_idx] <= 1'b1;
                  slot             <= free_idx;
                  next_order       <= order_inc;
                  tmo              <= tmo_c;
                  state            <= owner_present ? S_ACQ_END : S_SCAN;
                end
              end
            end
            OP_RELEASE: begin
              mode_tick <= 1'b0;
              if (match && (owner_depth <= 8'd1)) begin
                owner_present <= 1'b0;
                owner_id      <= '0;
                owner_since   <= '0;
                streak        <= '0;
                state         <= S_SCAN;
              end
            end
            OP_TICK: begin
              mode_tick <= 1'b1;
              state     <= S_SCAN;
            end
            default: begin
              state <= S_FLUSH;
            end
          endcase
        end
        S_SCAN: begin
          if (!stall) begin
            if (cmp_v && !mode_tick && wvalid[cmp_i] && better) begin
              best_v   <= 1'b1;
              best_i   <= cmp_i;
              best_cls <= rd_cls;
              best_ord <= rd_ord;
            end
            if (tick_hit) begin
              wvalid[cmp_i] <= 1'b0;
              found         <= found + FW'(1);
              streak        <= streak_inc;
            end
            if (scan_end) begin
              if (mode_tick) begin
                state <= S_FLUSH;
              end else if (it.opcode == OP_ACQUIRE) begin
                state <= S_ACQ_END;
              end else begin
                state <= best_v ? S_GRANT_RD : S_FLUSH;
              end
            end else if (s < SW'(N)) begin
              cmp_v <= 1'b1;
              cmp_i <= s[IW-1:0];
              s     <= s + SW'(1);
            end else begin
              cmp_v <= 1'b0;
            end
          end
        end
        S_ACQ_END: begin
          if (go) begin
            if (grant_here) begin
              state <= S_GRANT_RD;
            end else begin
              if (tmo == 32'd0) begin
                wvalid[slot] <= 1'b0;
                streak       <= streak_inc;
              end
              state <= S_FLUSH;
            end
          end
        end
        S_GRANT_RD: begin
          state <= S_GRANT;
        end
        S_GRANT: begin
          if (go) begin
            owner_present  <= 1'b1;
            owner_id       <= rd_task;
            owner_gen      <= gen_next;
            owner_since    <= it.now_ms;
            wvalid[best_i] <= 1'b0;
            state          <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (can_push) begin
            out_data   <= pend_last;
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

[rtl/sbpla_checker.sv]
// Port-level checks for the lock arbiter result channel, bound to the top level.
// Depends on sbpla_pkg.
module sbpla_checker
  import sbpla_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input res_t res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(res))
    else $error("result beat dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result beat right after reset");

  a_no_gen: assert property (@(posedge clk) disable iff (rst)
    valid && (res.kind == K_QUEUED || res.kind == K_BUSY || res.kind == K_TIMEDOUT)
    |-> res.generation == 32'd0)
    else $error("waiter result carries a generation");

  a_grant: assert property (@(posedge clk) disable iff (rst)
    valid && res.kind == K_GRANTED |-> res.depth == 8'd1 && res.generation != 32'd0)
    else $error("grant with bad depth or zero generation");

  a_wait: assert property (@(posedge clk) disable iff (rst)
    valid && (res.kind == K_NESTED || res.kind == K_PARTIAL || res.kind == K_MISMATCH ||
              res.kind == K_FULL || res.kind == K_QUEUED) |-> res.wait_ms == 32'd0)
    else $error("nonzero wait on a result without one");

endmodule

bind shared_bus_priority_lock_arbiter sbpla_checker u_sbpla_checker (
  .clk   (clk),
  .rst   (rst),
  .valid (rsp.valid),
  .ready (rsp.ready),
  .res   (rsp.data)
);
